@@ hw/rtl/mst_pkg.sv @@
// Shared types and constants for the minimum spanning tree block.
`default_nettype none
package mst_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Configuration register and vertex fields inside control structs.
  localparam int CFG_W    = 6;
  localparam int VTX_W    = 6;
  localparam int TOT_W    = 21;
  localparam int SUM_W    = 34;
  localparam logic [TOT_W-1:0] TOTAL_MAX = 21'h1FFFFF;
  localparam logic [CFG_W-1:0] VCOUNT_RESET = 6'd32;

  // Lookup item travelling down the label chain.
  typedef struct packed {
    logic             valid;
    logic [VTX_W-1:0] u;
    logic [VTX_W-1:0] v;
    logic [VTX_W-1:0] lu;
    logic [VTX_W-1:0] lv;
  } token_t;

  // Merge command broadcast to every cell.
  typedef struct packed {
    logic             init;
    logic             en;
    logic [VTX_W-1:0] from;
    logic [VTX_W-1:0] to;
  } relabel_t;

endpackage
`default_nettype wire

@@ hw/rtl/mst_cell.sv @@
// One label cell: holds the component label of one vertex and passes the lookup item on.
`default_nettype none
module mst_cell #(
  parameter int VW    = 5,
  parameter int INDEX = 0
) (
  input  wire                clk,
  input  wire                rst,
  input  mst_pkg::relabel_t  cmd,
  input  mst_pkg::token_t    tok_in,
  output mst_pkg::token_t    tok_out
);

  logic [VW-1:0] label;
  logic [mst_pkg::VTX_W-1:0] label_ext;
  logic [mst_pkg::VTX_W-1:0] my_index;

  assign label_ext = mst_pkg::VTX_W'(label);
  assign my_index  = mst_pkg::VTX_W'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      label <= VW'(INDEX);
    end else if (cmd.en && label_ext == cmd.from) begin
      label <= cmd.to[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.u  <= tok_in.u;
    tok_out.v  <= tok_in.v;
    tok_out.lu <= (tok_in.u == my_index) ? label_ext : tok_in.lu;
    tok_out.lv <= (tok_in.v == my_index) ? label_ext : tok_in.lv;
  end

endmodule
`default_nettype wire

@@ hw/rtl/mst_chain.sv @@
// Row of label cells, one per vertex, that a lookup item walks through.
`default_nettype none
module mst_chain #(
  parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
  parameter int VW           = 5
) (
  input  wire                clk,
  input  wire                rst,
  input  mst_pkg::relabel_t  cmd,
  input  mst_pkg::token_t    tok_in,
  output mst_pkg::token_t    tok_out
);

  mst_pkg::token_t link [MAX_VERTICES+1];

  assign link[0] = tok_in;
  assign tok_out = link[MAX_VERTICES];

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    mst_cell #(.VW(VW), .INDEX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

endmodule
`default_nettype wire

@@ hw/rtl/minimum_spanning_tree_kruskal.sv @@
// Top level: Kruskal minimum spanning tree over a streamed adjacency matrix.
// Input channel (in_valid/in_ready) takes one matrix entry per cycle while loading.
// Upper-triangle entries with nonzero weight inside vertex_count are kept as edges.
// The item with last set starts the run; in_ready stays low until the summary is queued.
// Edges are taken in ascending weight order (ties in arrival order) by one scan of
// the edge memory per examined edge, then a lookup walks the label chain; when
// the graph is not connected, one more scan finds no edge left and ends the run.
// A connected graph yields its tree edges in acceptance order and then a summary
// with the total weight; otherwise only a summary with connected low.
// The output channel (out_valid/out_ready) is one register; a stalled receiver
// simply holds the run. The config channel writes vertex_count at any time the
// block is idle; cfg_ready is high whenever rst is low.
// Reset (rst, synchronous) empties the edge memory count and sets vertex_count to 32;
// in_ready and cfg_ready stay low while rst is high.
// Memories need no clearing pass; only entries written in this run are read.
`default_nettype none
module minimum_spanning_tree_kruskal #(
  parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [mst_pkg::CFG_W-1:0]  cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [$clog2(MAX_VERTICES)-1:0]  row_index,
  input  wire [$clog2(MAX_VERTICES)-1:0]  col_index,
  input  wire [WEIGHT_BITS-1:0]     weight,
  input  wire                       last,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic                      is_summary,
  output logic [$clog2(MAX_VERTICES)-1:0] edge_u,
  output logic [$clog2(MAX_VERTICES)-1:0] edge_v,
  output logic [WEIGHT_BITS-1:0]    edge_weight,
  output logic                      connected,
  output logic [mst_pkg::TOT_W-1:0] total_weight,
  output logic                      last_result
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int ED = (MAX_VERTICES * (MAX_VERTICES - 1)) / 2;
  localparam int EW = $clog2(ED + 1);
  localparam int EA = (ED > 1) ? $clog2(ED) : 1;
  localparam int MW = 2 * VW + WEIGHT_BITS;
  localparam int KW = WEIGHT_BITS + EW;
  localparam int CW = mst_pkg::CFG_W;
  localparam int XW = mst_pkg::VTX_W;

  typedef enum logic [6:0] {
    S_LOAD      = 7'b0000001,
    S_INIT      = 7'b0000010,
    S_SCAN      = 7'b0000100,
    S_LOOK      = 7'b0001000,
    S_EMIT_RD   = 7'b0010000,
    S_EMIT_WAIT = 7'b0100000,
    S_SUM       = 7'b1000000
  } state_t;

  state_t state;

  logic [CW-1:0] vertex_count;
  logic [CW-1:0] n_act;
  logic [CW-1:0] n_less;

  logic [MW-1:0] edge_mem [ED];
  logic [MW-1:0] edge_rd;
  logic [EW-1:0] edge_total;
  logic [EW-1:0] rd_cnt;
  logic [EW-1:0] rd_idx;
  logic          rd_vld;

  logic [MW-1:0] tree_mem [MAX_VERTICES];
  logic [MW-1:0] tree_rd;
  logic [VW-1:0] tree_total;
  logic [VW-1:0] e_cnt;

  logic [KW-1:0] prev_key;
  logic          have_prev;
  logic [KW-1:0] best_key;
  logic          best_vld;
  logic [VW-1:0] best_u;
  logic [VW-1:0] best_v;
  logic [WEIGHT_BITS-1:0] best_w;

  logic [mst_pkg::TOT_W-1:0] acc;
  logic [mst_pkg::SUM_W-1:0] acc_sum;

  mst_pkg::token_t   tok_in;
  mst_pkg::token_t   tok_out;
  mst_pkg::relabel_t cmd;

  logic in_acc;
  logic keep_edge;
  logic out_free;
  logic scan_end;
  logic cand_ok;
  logic [VW-1:0]          rd_u;
  logic [VW-1:0]          rd_v;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [KW-1:0]          rd_key;
  logic                   merge;

  assign cfg_ready = !rst;
  assign in_ready  = (state == S_LOAD) && !rst;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (vertex_count == '0) begin
      n_act = CW'(1);
    end else if (vertex_count > CW'(MAX_VERTICES)) begin
      n_act = CW'(MAX_VERTICES);
    end else begin
      n_act = vertex_count;
    end
  end
  assign n_less = n_act - CW'(1);

  assign keep_edge = (col_index > row_index) && (weight != '0) &&
                     (CW'(col_index) < n_act) && (edge_total < EW'(ED));

  assign rd_u   = edge_rd[MW-1 -: VW];
  assign rd_v   = edge_rd[MW-VW-1 -: VW];
  assign rd_w   = edge_rd[WEIGHT_BITS-1:0];
  assign rd_key = {rd_w, rd_idx};
  assign cand_ok = (CW'(rd_u) < n_act) && (CW'(rd_v) < n_act) &&
                   (!have_prev || rd_key > prev_key) &&
                   (!best_vld || rd_key < best_key);
  assign scan_end = (rd_cnt == edge_total) && !rd_vld;

  assign merge   = tok_out.valid && (tok_out.lu != tok_out.lv);
  assign acc_sum = mst_pkg::SUM_W'(acc) + mst_pkg::SUM_W'(best_w);

  always_comb begin
    cmd.init = (state == S_INIT);
    cmd.en   = (state == S_LOOK) && merge;
    cmd.from = tok_out.lv;
    cmd.to   = tok_out.lu;
  end

  mst_chain #(.MAX_VERTICES(MAX_VERTICES), .VW(VW)) u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .tok_in  (tok_in),
    .tok_out (tok_out)
  );

  // Edge memory: written while loading, read back during the scans.
  always_ff @(posedge clk) begin
    if (in_acc && keep_edge) begin
      edge_mem[edge_total[EA-1:0]] <= {row_index, col_index, weight};
    end
    if (state == S_SCAN && rd_cnt < edge_total) begin
      edge_rd <= edge_mem[rd_cnt[EA-1:0]];
    end
  end

  // Tree memory: written on every merge, read back for the output items.
  always_ff @(posedge clk) begin
    if (state == S_LOOK && merge) begin
      tree_mem[tree_total] <= {best_u, best_v, best_w};
    end
    if (state == S_EMIT_RD && e_cnt != tree_total) begin
      tree_rd <= tree_mem[e_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      vertex_count <= mst_pkg::VCOUNT_RESET;
      edge_total   <= '0;
      tree_total   <= '0;
      out_valid    <= 1'b0;
      tok_in.valid <= 1'b0;
      rd_vld       <= 1'b0;
      rd_cnt       <= '0;
      have_prev    <= 1'b0;
      best_vld     <= 1'b0;
      e_cnt        <= '0;
      acc          <= '0;
    end else begin
      if (cfg_valid) begin
        vertex_count <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      tok_in.valid <= 1'b0;

      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (keep_edge) begin
              edge_total <= edge_total + EW'(1);
            end
            if (last) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          tree_total <= '0;
          acc        <= '0;
          have_prev  <= 1'b0;
          e_cnt      <= '0;
          rd_cnt     <= '0;
          rd_vld     <= 1'b0;
          best_vld   <= 1'b0;
          state      <= (n_less == '0) ? S_EMIT_RD : S_SCAN;
        end
        S_SCAN: begin
          if (rd_cnt < edge_total) begin
            rd_cnt <= rd_cnt + EW'(1);
            rd_idx <= rd_cnt;
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld && cand_ok) begin
            best_vld <= 1'b1;
            best_key <= rd_key;
            best_u   <= rd_u;
            best_v   <= rd_v;
            best_w   <= rd_w;
          end
          if (scan_end) begin
            if (best_vld) begin
              prev_key     <= best_key;
              have_prev    <= 1'b1;
              tok_in.valid <= 1'b1;
              tok_in.u     <= XW'(best_u);
              tok_in.v     <= XW'(best_v);
              tok_in.lu    <= '0;
              tok_in.lv    <= '0;
              state        <= S_LOOK;
            end else begin
              state <= S_SUM;
            end
          end
        end
        S_LOOK: begin
          if (tok_out.valid) begin
            rd_cnt   <= '0;
            rd_vld   <= 1'b0;
            best_vld <= 1'b0;
            state    <= S_SCAN;
            if (merge) begin
              tree_total <= tree_total + VW'(1);
              acc <= (acc_sum > mst_pkg::SUM_W'(mst_pkg::TOTAL_MAX)) ?
                     mst_pkg::TOTAL_MAX : acc_sum[mst_pkg::TOT_W-1:0];
              if (CW'(tree_total) + CW'(1) == n_less) begin
                state <= S_EMIT_RD;
              end
            end
          end
        end
        S_EMIT_RD: begin
          state <= (e_cnt == tree_total) ? S_SUM : S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            is_summary  <= 1'b0;
            edge_u      <= tree_rd[MW-1 -: VW];
            edge_v      <= tree_rd[MW-VW-1 -: VW];
            edge_weight <= tree_rd[WEIGHT_BITS-1:0];
            connected   <= 1'b0;
            total_weight <= '0;
            last_result <= 1'b0;
            e_cnt       <= e_cnt + VW'(1);
            state       <= S_EMIT_RD;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            is_summary   <= 1'b1;
            edge_u       <= '0;
            edge_v       <= '0;
            edge_weight  <= '0;
            connected    <= (CW'(tree_total) == n_less);
            total_weight <= (CW'(tree_total) == n_less) ? acc : '0;
            last_result  <= 1'b1;
            edge_total   <= '0;
            tree_total   <= '0;
            state        <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
